// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the JSON string unescape unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam int PhaseW = 3;
  localparam int CpW    = 16;
  localparam int ByteW  = 8;
  localparam int KindW  = 2;
  localparam int ErrW   = 2;
  localparam int CntW   = 2;
  localparam int MaxRes = 3;

  localparam logic [PhaseW-1:0] PH_IDLE = 3'd0;
  localparam logic [PhaseW-1:0] PH_STR  = 3'd1;
  localparam logic [PhaseW-1:0] PH_ESC  = 3'd2;
  localparam logic [PhaseW-1:0] PH_HEX1 = 3'd3;
  localparam logic [PhaseW-1:0] PH_HEX2 = 3'd4;
  localparam logic [PhaseW-1:0] PH_HEX3 = 3'd5;
  localparam logic [PhaseW-1:0] PH_HEX4 = 3'd6;

  localparam logic [KindW-1:0] K_DATA  = 2'd0;
  localparam logic [KindW-1:0] K_CLOSE = 2'd1;
  localparam logic [KindW-1:0] K_ERROR = 2'd2;

  localparam logic [ErrW-1:0] E_NONE   = 2'd0;
  localparam logic [ErrW-1:0] E_ESC    = 2'd1;
  localparam logic [ErrW-1:0] E_HEX    = 2'd2;
  localparam logic [ErrW-1:0] E_UNTERM = 2'd3;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic [ErrW-1:0]  err;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]  cnt;
    res_t [MaxRes-1:0] res;
  } bundle_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [CpW-1:0]    cp;
    bundle_t           bun;
  } dec_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/jsu_dec.sv =====
// ----------------------------------------------------------------------------
// jsu_dec
// Combinational decode of one string byte against the current decoder state.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_dec (
  input  wire logic [jsu_pkg::PhaseW-1:0] phase,
  input  wire logic [jsu_pkg::CpW-1:0]    cp,
  input  wire logic                       start_req,
  input  wire logic [jsu_pkg::ByteW-1:0]  text_byte,
  input  wire logic                       end_of_text,
  output jsu_pkg::dec_out_t               dec
);

  logic [jsu_pkg::PhaseW-1:0] ph;
  logic [jsu_pkg::CpW-1:0]    cp_in;
  logic [jsu_pkg::CpW-1:0]    cp_new;
  logic [3:0]                 hex;
  logic                       hex_ok;
  logic [jsu_pkg::ByteW-1:0]  esc;
  logic                       esc_ok;

  always_comb begin
    hex    = 4'd0;
    hex_ok = 1'b1;
    if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
      hex = text_byte[3:0];
    end else if ((text_byte >= 8'h61 && text_byte <= 8'h66) ||
                 (text_byte >= 8'h41 && text_byte <= 8'h46)) begin
      hex = text_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok = 1'b1;
    case (text_byte)
      8'h22:   esc = 8'h22;
      8'h5C:   esc = 8'h5C;
      8'h2F:   esc = 8'h2F;
      8'h62:   esc = 8'h08;
      8'h66:   esc = 8'h0C;
      8'h6E:   esc = 8'h0A;
      8'h72:   esc = 8'h0D;
      8'h74:   esc = 8'h09;
      default: begin
        esc    = 8'h00;
        esc_ok = 1'b0;
      end
    endcase
  end

  assign ph     = start_req ? jsu_pkg::PH_STR : phase;
  assign cp_in  = start_req ? '0 : cp;
  assign cp_new = {cp_in[jsu_pkg::CpW-5:0], hex};

  always_comb begin
    dec       = '0;
    dec.phase = ph;
    dec.cp    = cp_in;
    if (ph == jsu_pkg::PH_IDLE || ph > jsu_pkg::PH_HEX4) begin
      dec.phase = jsu_pkg::PH_IDLE;
    end else if (end_of_text) begin
      dec.bun.cnt           = 2'd1;
      dec.bun.res[0].kind   = jsu_pkg::K_ERROR;
      dec.bun.res[0].err    = jsu_pkg::E_UNTERM;
      dec.phase             = jsu_pkg::PH_IDLE;
    end else if (ph == jsu_pkg::PH_STR) begin
      if (text_byte == 8'h22) begin
        dec.bun.cnt         = 2'd1;
        dec.bun.res[0].kind = jsu_pkg::K_CLOSE;
        dec.phase           = jsu_pkg::PH_IDLE;
      end else if (text_byte == 8'h5C) begin
        dec.phase           = jsu_pkg::PH_ESC;
      end else begin
        dec.bun.cnt         = 2'd1;
        dec.bun.res[0].kind = jsu_pkg::K_DATA;
        dec.bun.res[0].data = text_byte;
      end
    end else if (ph == jsu_pkg::PH_ESC) begin
      if (esc_ok) begin
        dec.bun.cnt         = 2'd1;
        dec.bun.res[0].data = esc;
        dec.phase           = jsu_pkg::PH_STR;
      end else if (text_byte == 8'h75) begin
        dec.cp              = '0;
        dec.phase           = jsu_pkg::PH_HEX1;
      end else begin
        dec.bun.cnt         = 2'd1;
        dec.bun.res[0].kind = jsu_pkg::K_ERROR;
        dec.bun.res[0].err  = jsu_pkg::E_ESC;
        dec.phase           = jsu_pkg::PH_IDLE;
      end
    end else if (!hex_ok) begin
      dec.bun.cnt           = 2'd1;
      dec.bun.res[0].kind   = jsu_pkg::K_ERROR;
      dec.bun.res[0].err    = jsu_pkg::E_HEX;
      dec.phase             = jsu_pkg::PH_IDLE;
    end else if (ph == jsu_pkg::PH_HEX4) begin
      dec.cp    = '0;
      dec.phase = jsu_pkg::PH_STR;
      if (cp_new < 16'h0080) begin
        dec.bun.cnt         = 2'd1;
        dec.bun.res[0].data = cp_new[7:0];
      end else if (cp_new < 16'h0800) begin
        dec.bun.cnt         = 2'd2;
        dec.bun.res[0].data = {3'b110, cp_new[10:6]};
        dec.bun.res[1].data = {2'b10, cp_new[5:0]};
      end else begin
        dec.bun.cnt         = 2'd3;
        dec.bun.res[0].data = {4'b1110, cp_new[15:12]};
        dec.bun.res[1].data = {2'b10, cp_new[11:6]};
        dec.bun.res[2].data = {2'b10, cp_new[5:0]};
      end
    end else begin
      dec.cp    = cp_new;
      dec.phase = ph + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/json_string_unescape_utf8_unit.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Streaming decoder of JSON string bodies into UTF-8 bytes.
// ----------------------------------------------------------------------------
// An input byte is registered, decoded combinationally into a group of up to
// three results, and the group waits in an output register while it is sent
// one result per cycle while out_tready is high. A new byte is taken every
// cycle as long as each byte gives at most one result and the output is not
// stalled; a unicode escape that yields two or three bytes holds the input
// while the output register drains. An input transfer is held in the input
// register, then its results are loaded into the output register.
`default_nettype none

module json_string_unescape_utf8_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tuser,   // [0] start_req
  input  wire logic       in_tlast,   // end_of_text
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [15:0] out_tdata, // [7:0] data_byte, [9:8] error_code, rest 0
  output      logic [1:0] out_tuser,  // [1:0] kind
  output      logic       out_tlast   // last
);

  logic                       s1_vld_r;
  logic                       s1_start_r;
  logic [jsu_pkg::ByteW-1:0]  s1_byte_r;
  logic                       s1_eot_r;
  logic [jsu_pkg::PhaseW-1:0] phase_r;
  logic [jsu_pkg::CpW-1:0]    cp_r;
  logic                       bv_r;
  jsu_pkg::bundle_t           bun_r;
  logic [jsu_pkg::CntW-1:0]   idx_r;

  jsu_pkg::dec_out_t dec;
  jsu_pkg::res_t     cur;
  logic              in_fire;
  logic              out_fire;
  logic              bun_done;
  logic              bun_free;
  logic              s1_adv;
  logic              load;

  jsu_dec u_dec (
    .phase       (phase_r),
    .cp          (cp_r),
    .start_req   (s1_start_r),
    .text_byte   (s1_byte_r),
    .end_of_text (s1_eot_r),
    .dec         (dec)
  );

  assign cur       = bun_r.res[idx_r];
  assign out_fire  = out_tvalid && out_tready;
  assign bun_done  = out_fire && (idx_r == bun_r.cnt - 2'd1);
  assign bun_free  = !bv_r || bun_done;
  assign s1_adv    = s1_vld_r && (bun_free || dec.bun.cnt == 2'd0);
  assign load      = s1_adv && dec.bun.cnt != 2'd0;
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = bv_r;
  assign out_tuser  = cur.kind;
  assign out_tdata  = {6'd0, cur.err, cur.data};
  assign out_tlast  = idx_r == bun_r.cnt - 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      phase_r  <= jsu_pkg::PH_IDLE;
      cp_r     <= '0;
      bv_r     <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        phase_r <= dec.phase;
        cp_r    <= dec.cp;
      end
      if (load) begin
        bv_r  <= 1'b1;
        idx_r <= '0;
      end else if (bun_done) begin
        bv_r  <= 1'b0;
      end else if (out_fire) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r <= in_tuser;
      s1_byte_r  <= in_tdata;
      s1_eot_r   <= in_tlast;
    end
    if (load) begin
      bun_r <= dec.bun;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level assertions for the JSON string unescape unit.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_no_out_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("result shown right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("result kind out of range");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == jsu_pkg::K_ERROR) |->
      (out_tlast && out_tdata[7:0] == 8'd0 && out_tdata[9:8] != jsu_pkg::E_NONE))
    else $error("malformed error result");

  a_close_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != jsu_pkg::K_ERROR) |-> out_tdata[15:8] == 8'd0)
    else $error("error code set on a non-error result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result transfer changed");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== tb/json_string_unescape_utf8_unit_tb.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit_tb
// Self-checking bench for the JSON string body decoder. A queue of text bytes
// (directed cases, then random strings with plain bytes, simple escapes,
// unicode escapes and broken endings, mixed with stray noise bytes) feeds a stream
// driver; each accepted transfer updates a local decoder that predicts the
// UTF-8 bytes, close and error results, which a monitor checks in order.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] QUOTE    = 8'h22;
  localparam logic [7:0] BSLASH   = 8'h5C;
  localparam logic [7:0] LETTER_U = 8'h75;
  localparam int         QUIET_TAIL = 60;

  typedef struct {
    bit         start;
    logic [7:0] ch;
    bit         eot;
    bit         drain;
  } text_item_t;

  typedef struct {
    logic [jsu_pkg::KindW-1:0] kind;
    logic [7:0]                data;
    logic [jsu_pkg::ErrW-1:0]  err;
    logic                      last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] text_byte
  logic        in_tuser = 1'b0; // [0] start_req
  logic        in_tlast = 1'b0; // end_of_text
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] data_byte, [9:8] error_code, rest 0
  logic [1:0]  out_tuser;       // [1:0] kind
  logic        out_tlast;

  text_item_t  text_q[$];
  decoded_t    utf8_expect_q[$];

  logic [jsu_pkg::PhaseW-1:0] dec_phase = jsu_pkg::PH_IDLE;
  logic [jsu_pkg::CpW-1:0]    dec_cp = '0;

  int  send_gap = 0;
  int  recv_stall = 0;
  bit  quiet = 1'b0;
  int  mismatches = 0;
  int  n_noise = 0;
  int  n_strings = 0;
  int  n_transfers = 0;
  int  n_checked = 0;
  int  n_closed = 0;
  int  n_errors = 0;
  string esc_letters = "\"\\/bfnrt";

  json_string_unescape_utf8_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic int escape_byte(logic [7:0] c);
    case (c)
      QUOTE:  return QUOTE;
      BSLASH: return BSLASH;
      "/":    return 8'h2F;
      "b":    return 8'h08;
      "f":    return 8'h0C;
      "n":    return 8'h0A;
      "r":    return 8'h0D;
      "t":    return 8'h09;
      default: return -1;
    endcase
  endfunction

  function automatic decoded_t make_result(logic [jsu_pkg::KindW-1:0] kind,
                                           logic [7:0] data,
                                           logic [jsu_pkg::ErrW-1:0] err);
    decoded_t r;
    r.kind = kind;
    r.data = data;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic unescape_step(input bit start, input logic [7:0] ch, input bit eot);
    decoded_t res[$];
    int       nib;
    int       esc;
    if (start) begin
      dec_phase = jsu_pkg::PH_STR;
      dec_cp = '0;
    end
    if (dec_phase == jsu_pkg::PH_IDLE || dec_phase > jsu_pkg::PH_HEX4) begin
      dec_phase = jsu_pkg::PH_IDLE;
    end else if (eot) begin
      res.insert(res.size(), make_result(jsu_pkg::K_ERROR, 8'h00, jsu_pkg::E_UNTERM));
      dec_phase = jsu_pkg::PH_IDLE;
    end else if (dec_phase == jsu_pkg::PH_STR) begin
      if (ch == QUOTE) begin
        res.insert(res.size(), make_result(jsu_pkg::K_CLOSE, 8'h00, jsu_pkg::E_NONE));
        dec_phase = jsu_pkg::PH_IDLE;
      end else if (ch == BSLASH) begin
        dec_phase = jsu_pkg::PH_ESC;
      end else begin
        res.insert(res.size(), make_result(jsu_pkg::K_DATA, ch, jsu_pkg::E_NONE));
      end
    end else if (dec_phase == jsu_pkg::PH_ESC) begin
      esc = escape_byte(ch);
      if (esc >= 0) begin
        res.insert(res.size(), make_result(jsu_pkg::K_DATA, esc[7:0], jsu_pkg::E_NONE));
        dec_phase = jsu_pkg::PH_STR;
      end else if (ch == LETTER_U) begin
        dec_cp = '0;
        dec_phase = jsu_pkg::PH_HEX1;
      end else begin
        res.insert(res.size(), make_result(jsu_pkg::K_ERROR, 8'h00, jsu_pkg::E_ESC));
        dec_phase = jsu_pkg::PH_IDLE;
      end
    end else begin
      nib = hex_nibble(ch);
      if (nib < 0) begin
        res.insert(res.size(), make_result(jsu_pkg::K_ERROR, 8'h00, jsu_pkg::E_HEX));
        dec_phase = jsu_pkg::PH_IDLE;
      end else begin
        dec_cp = {dec_cp[11:0], nib[3:0]};
        if (dec_phase == jsu_pkg::PH_HEX4) begin
          if (dec_cp < 16'h0080) begin
            res.insert(res.size(),
                       make_result(jsu_pkg::K_DATA, dec_cp[7:0], jsu_pkg::E_NONE));
          end else if (dec_cp < 16'h0800) begin
            res.insert(res.size(), make_result(jsu_pkg::K_DATA,
                                               {3'b110, dec_cp[10:6]}, jsu_pkg::E_NONE));
            res.insert(res.size(), make_result(jsu_pkg::K_DATA,
                                               {2'b10, dec_cp[5:0]}, jsu_pkg::E_NONE));
          end else begin
            res.insert(res.size(), make_result(jsu_pkg::K_DATA,
                                               {4'b1110, dec_cp[15:12]}, jsu_pkg::E_NONE));
            res.insert(res.size(), make_result(jsu_pkg::K_DATA,
                                               {2'b10, dec_cp[11:6]}, jsu_pkg::E_NONE));
            res.insert(res.size(), make_result(jsu_pkg::K_DATA,
                                               {2'b10, dec_cp[5:0]}, jsu_pkg::E_NONE));
          end
          dec_cp = '0;
          dec_phase = jsu_pkg::PH_STR;
        end else begin
          dec_phase = dec_phase + 1'b1;
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) utf8_expect_q.insert(utf8_expect_q.size(), res[i]);
  endtask

  task automatic push_text(input bit start, input logic [7:0] ch, input bit eot,
                           input bit drain = 1'b0);
    text_item_t t;
    t.start = start;
    t.ch    = ch;
    t.eot   = eot;
    t.drain = drain;
    text_q.insert(text_q.size(), t);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  task automatic push_unicode(input logic [15:0] cp);
    push_text(1'b0, BSLASH, 1'b0);
    push_text(1'b0, LETTER_U, 1'b0);
    for (int i = 3; i >= 0; i--) push_text(1'b0, hex_char(cp[i*4 +: 4]), 1'b0);
  endtask

  task automatic gen_string(input bit drain_first);
    int          len;
    int          k;
    logic [15:0] cp;
    logic [7:0]  c;
    n_strings++;
    len = $urandom_range(0, 8);
    do c = 8'($urandom_range(0, 255)); while (c == QUOTE || c == BSLASH);
    if (len > 0 && $urandom_range(0, 3) != 0) begin
      push_text(1'b1, c, 1'b0, drain_first);
      len--;
    end else begin
      push_text(1'b1, QUOTE, 1'b0, drain_first);
      return;
    end
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          do c = 8'($urandom_range(0, 255)); while (c == QUOTE || c == BSLASH);
          push_text(1'b0, c, 1'b0);
        end
        3: begin
          push_text(1'b0, BSLASH, 1'b0);
          push_text(1'b0, esc_letters[$urandom_range(0, 7)], 1'b0);
        end
        default: begin
          case ($urandom_range(0, 4))
            0: cp = 16'($urandom_range(16'h0000, 16'h007F));
            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
            default: begin
              case ($urandom_range(0, 5))
                0: cp = 16'h0000;
                1: cp = 16'h007F;
                2: cp = 16'h0080;
                3: cp = 16'h07FF;
                4: cp = 16'h0800;
                default: cp = 16'hFFFF;
              endcase
            end
          endcase
          push_unicode(cp);
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: push_text(1'b0, QUOTE, 1'b0);
      6: begin
        push_text(1'b0, BSLASH, 1'b0);
        do c = 8'($urandom_range(0, 255)); while (escape_byte(c) >= 0 || c == LETTER_U);
        push_text(1'b0, c, 1'b0);
      end
      7: begin
        push_text(1'b0, BSLASH, 1'b0);
        push_text(1'b0, LETTER_U, 1'b0);
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) push_text(1'b0, hex_char(4'($urandom_range(0, 15))), 1'b0);
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
        push_text(1'b0, c, 1'b0);
      end
      8: begin
        k = $urandom_range(0, 5);
        if (k > 0) push_text(1'b0, BSLASH, 1'b0);
        if (k > 1) push_text(1'b0, LETTER_U, 1'b0);
        for (int i = 2; i < k; i++) push_text(1'b0, hex_char(4'($urandom_range(0, 15))), 1'b0);
        push_text(1'b0, 8'($urandom_range(0, 255)), 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Sender: one transfer per accepted handshake, random idle bursts until the tail.
  always @(posedge clk) begin
    text_item_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        unescape_step(in_tuser, in_tdata, in_tlast);
        n_transfers++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (text_q.size() < QUIET_TAIL) quiet = 1'b1;
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (text_q.size() == 0 ||
                     (text_q[0].drain && utf8_expect_q.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
          in_tvalid <= 1'b0;
        end else begin
          t = text_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= t.ch;
          in_tuser  <= t.start;
          in_tlast  <= t.eot;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (utf8_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d tdata %04h last %0d",
                                    out_tuser, out_tdata, out_tlast));
        end else begin
          want = utf8_expect_q.pop_front();
          n_checked++;
          if (want.kind == jsu_pkg::K_CLOSE) n_closed++;
          if (want.kind == jsu_pkg::K_ERROR) n_errors++;
          if (out_tuser !== want.kind || out_tdata !== {6'b0, want.err, want.data} ||
              out_tlast !== want.last) begin
            report_mismatch($sformatf(
              {"expected kind %0d data %02h err %0d last %0d, ",
               "got kind %0d data %02h err %0d last %0d pad %02h"},
              want.kind, want.data, want.err, want.last,
              out_tuser, out_tdata[7:0], out_tdata[9:8], out_tlast, out_tdata[15:10]));
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int strings_done;
    push_text(1'b0, "x", 1'b0);
    push_text(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    push_text(1'b1, QUOTE, 1'b0);
    push_text(1'b1, 8'h00, 1'b1);
    push_text(1'b1, 8'h00, 1'b0);
    push_text(1'b0, 8'hFF, 1'b0);
    push_text(1'b0, BSLASH, 1'b0);
    push_text(1'b0, "n", 1'b0);
    push_unicode(16'h0000);
    push_unicode(16'hFFFF);
    push_text(1'b0, BSLASH, 1'b0);
    push_text(1'b0, "q", 1'b0);
    push_text(1'b1, BSLASH, 1'b0);
    push_text(1'b0, LETTER_U, 1'b0);
    push_text(1'b0, "1", 1'b0);
    push_text(1'b0, "g", 1'b0);
    push_text(1'b1, BSLASH, 1'b0);
    push_text(1'b0, 8'h00, 1'b1);
    n_noise = 3;
    strings_done = 0;
    while (text_q.size() - n_noise < 430) begin
      gen_string(strings_done % 25 == 10);
      strings_done++;
      if ($urandom_range(0, 4) == 0) begin
        push_text(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        n_noise++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (text_q.size() != 0 || in_tvalid) @(posedge clk);
    while (utf8_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d input transfers over %0d random strings plus directed cases.",
             n_transfers, n_strings);
    $display("Checked %0d results: %0d string closes, %0d errors, %0d mismatches.",
             n_checked, n_closed, n_errors, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d inputs and %0d results still pending.",
             text_q.size(), utf8_expect_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ===== json_string_unescape_utf8_unit.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_dec.sv
rtl/core/json_string_unescape_utf8_unit.sv
rtl/core/jsu_checker.sv
tb/json_string_unescape_utf8_unit_tb.sv
